>>> hw/rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Types, codes and helpers shared by the speech endpoint detector.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int CNT_W   = 16;
  localparam int FRAME_W = 10;
  localparam int OP_W    = 3;
  localparam int CODE_W  = 3;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_FRAME_LEN   = 3'd0;
  localparam logic [2:0] REG_START_CONF  = 3'd1;
  localparam logic [2:0] REG_END_SIL     = 3'd2;
  localparam logic [2:0] REG_NO_SPEECH   = 3'd3;
  localparam logic [2:0] REG_MAX_UTT     = 3'd4;

  localparam logic [FRAME_W-1:0] RST_FRAME_LEN  = 10'd20;
  localparam logic [CNT_W-1:0]   RST_START_CONF = 16'd60;
  localparam logic [CNT_W-1:0]   RST_END_SIL    = 16'd100;
  localparam logic [CNT_W-1:0]   RST_NO_SPEECH  = 16'd200;
  localparam logic [CNT_W-1:0]   RST_MAX_UTT    = 16'd300;

  typedef enum logic [OP_W-1:0] {
    OP_FRAME   = 3'd0,
    OP_ARM     = 3'd1,
    OP_DISARM  = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_OVERRUN = 3'd4
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_TIMEOUT  = 3'd2,
    EV_MAX_UTT  = 3'd3,
    EV_END      = 3'd4,
    EV_CANCEL   = 3'd5,
    EV_OVERRUN  = 3'd6
  } event_t;

  typedef enum logic [CODE_W-1:0] {
    PH_DISARMED = 3'd0,
    PH_ARMED    = 3'd1,
    PH_STARTING = 3'd2,
    PH_SPEECH   = 3'd3,
    PH_HANGOVER = 3'd4,
    PH_COMPLETE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CMP_A  = 2'd1,
    ST_CMP_B  = 2'd2,
    ST_COMMIT = 2'd3
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_len;
    logic [CNT_W-1:0]   start_ms;
    logic [CNT_W-1:0]   end_ms;
    logic [CNT_W-1:0]   timeout_ms;
    logic [CNT_W-1:0]   max_ms;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == CNT_MAX) ? x : x + 16'd1;
  endfunction

endpackage

>>> hw/rtl/sed_ifs.sv
// ----------------------------------------------------------------------------
// sed_ifs
// Valid/ready channels: operation requests in, endpoint events out.
// ----------------------------------------------------------------------------
interface sed_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic       speech_flag;

  modport source (output valid, output operation, output speech_flag, input ready);
  modport sink   (input valid, input operation, input speech_flag, output ready);
endinterface

interface sed_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_code;
  logic [2:0]  phase_now;
  logic [15:0] utterance_count;

  modport source (output valid, output event_code, output phase_now,
                  output utterance_count, input ready);
  modport sink   (input valid, input event_code, input phase_now,
                  input utterance_count, output ready);
endinterface

>>> hw/rtl/sed_cfg_regs.sv
// ----------------------------------------------------------------------------
// sed_cfg_regs
// APB register file holding frame length and the millisecond thresholds.
// ----------------------------------------------------------------------------
module sed_cfg_regs
  import sed_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_len  <= RST_FRAME_LEN;
      cfg.start_ms   <= RST_START_CONF;
      cfg.end_ms     <= RST_END_SIL;
      cfg.timeout_ms <= RST_NO_SPEECH;
      cfg.max_ms     <= RST_MAX_UTT;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_LEN:  cfg.frame_len  <= pwdata[FRAME_W-1:0];
        REG_START_CONF: cfg.start_ms   <= pwdata[CNT_W-1:0];
        REG_END_SIL:    cfg.end_ms     <= pwdata[CNT_W-1:0];
        REG_NO_SPEECH:  cfg.timeout_ms <= pwdata[CNT_W-1:0];
        REG_MAX_UTT:    cfg.max_ms     <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_LEN:  prdata = {{(CFG_DW-FRAME_W){1'b0}}, cfg.frame_len};
      REG_START_CONF: prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg.start_ms};
      REG_END_SIL:    prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg.end_ms};
      REG_NO_SPEECH:  prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg.timeout_ms};
      REG_MAX_UTT:    prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg.max_ms};
      default:        prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/sed_mul_cmp.sv
// ----------------------------------------------------------------------------
// sed_mul_cmp
// Shared threshold unit: flags count * frame_len >= ms, i.e.
// count >= ceil(ms / frame_len), without a divider. Result is registered.
// ----------------------------------------------------------------------------
module sed_mul_cmp
  import sed_pkg::*;
(
  input  logic               clk,
  input  logic [CNT_W-1:0]   count,
  input  logic [FRAME_W-1:0] frame_len,
  input  logic [CNT_W-1:0]   ms,
  output logic               reached
);

  logic [CNT_W+FRAME_W-1:0] prod;

  assign prod = count * frame_len;

  always_ff @(posedge clk) begin
    reached <= (prod >= {{FRAME_W{1'b0}}, ms});
  end

endmodule

>>> hw/rtl/speech_endpoint_detector.sv
// ----------------------------------------------------------------------------
// speech_endpoint_detector
// Turns per-frame voice-activity requests into utterance endpoint events.
//
// cmd carries one request (frame with speech flag, arm, disarm, cancel,
// overrun); evt returns exactly one event per request with the new phase
// and the utterance count. Thresholds live in APB registers at 4*index.
// Each request runs through a small sequencer: two passes of one shared
// multiply-compare unit (count * frame_len vs ms), then a commit state
// that writes the event into the output register; cmd.ready is high only
// in the idle state, so no new request is taken until the last commits.
// The single output register holds an event while evt.ready is low; the
// next request may be accepted and waits in commit until it drains.
// Reset (rst, synchronous) restores register defaults, phase disarmed,
// all counters zero, and empties the output register.
// ----------------------------------------------------------------------------
module speech_endpoint_detector
  import sed_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sed_cmd_if.sink           cmd,
  sed_evt_if.source         evt,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  sed_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t            state, state_next;
  logic [OP_W-1:0]   op_q;
  logic              speech_q;
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  armed_cnt, armed_cnt_next;
  logic [CNT_W-1:0]  cand_cnt, cand_cnt_next;
  logic [CNT_W-1:0]  utt_len, utt_len_next;
  logic [CNT_W-1:0]  sil_cnt, sil_cnt_next;
  logic [CNT_W-1:0]  utt_num, utt_num_next;
  event_t            event_next;
  logic              ge_a;
  logic              unit_ge;
  logic              commit_en;
  logic              out_valid;
  event_t            out_event;
  phase_t            out_phase;
  logic [CNT_W-1:0]  out_count;

  logic [FRAME_W-1:0] frame_eff;
  logic [CNT_W-1:0]   armed_inc, cand_inc, utt_inc, sil_inc;
  logic [CNT_W-1:0]   unit_cnt, unit_ms;
  logic               arm_ph, speech_ph;

  assign frame_eff = (cfg.frame_len == '0) ? {{(FRAME_W-1){1'b0}}, 1'b1} : cfg.frame_len;
  assign armed_inc = sat_inc(armed_cnt);
  assign cand_inc  = sat_inc(cand_cnt);
  assign utt_inc   = sat_inc(utt_len);
  assign sil_inc   = sat_inc(sil_cnt);
  assign arm_ph    = (phase == PH_ARMED) || (phase == PH_STARTING);
  assign speech_ph = (phase == PH_SPEECH) || (phase == PH_HANGOVER);

  // pass A: start confirm / max length; pass B: timeout / end silence
  always_comb begin
    if (state == ST_CMP_A) begin
      unit_cnt = arm_ph ? cand_inc : utt_inc;
      unit_ms  = arm_ph ? cfg.start_ms : cfg.max_ms;
    end else begin
      unit_cnt = arm_ph ? armed_inc : sil_inc;
      unit_ms  = arm_ph ? cfg.timeout_ms : cfg.end_ms;
    end
  end

  sed_mul_cmp u_unit (
    .clk       (clk),
    .count     (unit_cnt),
    .frame_len (frame_eff),
    .ms        (unit_ms),
    .reached   (unit_ge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    commit_en  = 1'b0;
    cmd.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = ST_CMP_A;
        end
      end
      ST_CMP_A: state_next = ST_CMP_B;
      ST_CMP_B: state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (!out_valid || evt.ready) begin
          commit_en  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // next turn state; ge_a from pass A, unit_ge from pass B
  always_comb begin
    phase_next     = phase;
    armed_cnt_next = armed_cnt;
    cand_cnt_next  = cand_cnt;
    utt_len_next   = utt_len;
    sil_cnt_next   = sil_cnt;
    utt_num_next   = utt_num;
    event_next     = EV_NONE;
    case (op_q)
      OP_FRAME: begin
        if (arm_ph) begin
          armed_cnt_next = armed_inc;
          if (speech_q) begin
            cand_cnt_next = cand_inc;
            phase_next    = PH_STARTING;
          end else begin
            cand_cnt_next = '0;
            phase_next    = PH_ARMED;
          end
          if (speech_q && ge_a) begin
            utt_num_next = utt_num + 16'd1;
            utt_len_next = cand_inc;
            sil_cnt_next = '0;
            phase_next   = PH_SPEECH;
            event_next   = EV_START;
          end else if (unit_ge) begin
            phase_next = PH_COMPLETE;
            event_next = EV_TIMEOUT;
          end
        end else if (speech_ph) begin
          utt_len_next = utt_inc;
          if (ge_a) begin
            phase_next = PH_COMPLETE;
            event_next = EV_MAX_UTT;
          end else if (speech_q) begin
            sil_cnt_next = '0;
            phase_next   = PH_SPEECH;
          end else begin
            sil_cnt_next = sil_inc;
            phase_next   = PH_HANGOVER;
            if (unit_ge) begin
              phase_next = PH_COMPLETE;
              event_next = EV_END;
            end
          end
        end
      end
      OP_ARM, OP_DISARM: begin
        armed_cnt_next = '0;
        cand_cnt_next  = '0;
        utt_len_next   = '0;
        sil_cnt_next   = '0;
        phase_next     = (op_q == OP_ARM) ? PH_ARMED : PH_DISARMED;
      end
      OP_CANCEL, OP_OVERRUN: begin
        if (phase != PH_DISARMED && phase != PH_COMPLETE) begin
          phase_next = PH_COMPLETE;
          event_next = (op_q == OP_CANCEL) ? EV_CANCEL : EV_OVERRUN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q     <= cmd.operation;
      speech_q <= cmd.speech_flag;
    end
    if (state == ST_CMP_B) begin
      ge_a <= unit_ge;
    end
    if (commit_en) begin
      out_event <= event_next;
      out_phase <= phase_next;
      out_count <= utt_num_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DISARMED;
      armed_cnt <= '0;
      cand_cnt  <= '0;
      utt_len   <= '0;
      sil_cnt   <= '0;
      utt_num   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit_en) begin
        phase     <= phase_next;
        armed_cnt <= armed_cnt_next;
        cand_cnt  <= cand_cnt_next;
        utt_len   <= utt_len_next;
        sil_cnt   <= sil_cnt_next;
        utt_num   <= utt_num_next;
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign evt.valid           = out_valid;
  assign evt.event_code      = out_event;
  assign evt.phase_now       = out_phase;
  assign evt.utterance_count = out_count;

  // utterance count only ever steps by one
  a_utt_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(utt_num) |-> utt_num == $past(utt_num) + 16'd1)
    else $error("utterance count jumped");

  // a new event only appears right after a commit cycle
  a_evt_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_COMMIT))
    else $error("event without commit");

  // every terminating event leaves the turn complete
  a_end_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event != EV_NONE && out_event != EV_START
      |-> out_phase == PH_COMPLETE)
    else $error("ending event with live phase");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == EV_START |-> out_phase == PH_SPEECH)
    else $error("start event outside speech");

endmodule
